### sv/hsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsb_pkg: shared types and constants for the batch heap sorter
// Item payloads, sequencer status and default store depth.
// ----------------------------------------------------------------------------
package hsb_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     batch_end;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     final_flag;
      logic                     clipped;
   } rsp_type;

   // status from the sort sequencer to the top level
   typedef struct packed {
      logic busy;
      logic emit;
      logic last;
   } eng_status_type;

endpackage : hsb_pkg
`default_nettype wire

### sv/hsb_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsb_store: element memory
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module hsb_store #(
   parameter int DEPTH = hsb_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic [AW-1:0]             waddr,
   input  wire logic [hsb_pkg::DATA_W-1:0] wdata,
   input  wire logic [AW-1:0]             ra_addr,
   input  wire logic [AW-1:0]             rb_addr,
   output logic      [hsb_pkg::DATA_W-1:0] ra_data,
   output logic      [hsb_pkg::DATA_W-1:0] rb_data
);
   import hsb_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] ra_data_ff;
   logic [DATA_W-1:0] rb_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      ra_data_ff <= mem[ra_addr];
      rb_data_ff <= mem[rb_addr];
   end

   assign ra_data = ra_data_ff;
   assign rb_data = rb_data_ff;

endmodule : hsb_store
`default_nettype wire

### sv/hsb_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsb_engine: heapsort sequencer
// Builds a max-heap in the store, extracts it in place, then reads the
// sorted entries back out one at a time.
// ----------------------------------------------------------------------------
module hsb_engine #(
   parameter int DEPTH = hsb_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [CW-1:0]              len_in,
   input  wire logic                       out_room,
   output hsb_pkg::eng_status_type         status,
   output logic      [hsb_pkg::DATA_W-1:0] out_value,
   output logic                            mem_we,
   output logic      [AW-1:0]              mem_waddr,
   output logic      [hsb_pkg::DATA_W-1:0] mem_wdata,
   output logic      [AW-1:0]              ra_addr,
   output logic      [AW-1:0]              rb_addr,
   input  wire logic [hsb_pkg::DATA_W-1:0] ra_data,
   input  wire logic [hsb_pkg::DATA_W-1:0] rb_data
);
   import hsb_pkg::*;

   localparam int IW = AW + 2;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_H_RD = 9'b000000010,
      ST_H_LD = 9'b000000100,
      ST_S_RD = 9'b000001000,
      ST_S_CMP = 9'b000010000,
      ST_X_RD = 9'b000100000,
      ST_X_WR = 9'b001000000,
      ST_O_RD = 9'b010000000,
      ST_O_LD = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [CW-1:0]     len_ff, len_in_r;
   logic [CW-1:0]     k_ff, k_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [DATA_W-1:0] cur_ff, cur_in;
   logic              heap_phase_ff, heap_phase_in;

   logic [CW-1:0]     km1;
   logic [IW-1:0]     lc, rc, len_ext;
   logic              lc_ok, rc_ok, take_r, move;
   logic [DATA_W-1:0] child_val;
   logic [AW-1:0]     child_idx;

   assign km1     = k_ff - CW'(1);
   assign lc      = {1'b0, pos_ff, 1'b0} + IW'(1);
   assign rc      = lc + IW'(1);
   assign len_ext = {{(IW - CW){1'b0}}, len_ff};
   assign lc_ok   = lc < len_ext;
   assign rc_ok   = rc < len_ext;

   // larger child, right one only when strictly greater
   assign take_r    = rc_ok && ($signed(rb_data) > $signed(ra_data));
   assign child_val = take_r ? rb_data : ra_data;
   assign child_idx = take_r ? rc[AW-1:0] : lc[AW-1:0];
   assign move      = lc_ok && ($signed(child_val) > $signed(cur_ff));

   assign out_value = ra_data;

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      len_in_r      = len_ff;
      k_in          = k_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      heap_phase_in = heap_phase_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = cur_ff;
      ra_addr       = '0;
      rb_addr       = '0;
      status.busy   = (state_ff != ST_IDLE);
      status.emit   = 1'b0;
      status.last   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in = len_in;
               if (len_in < CW'(2)) begin
                  k_in     = '0;
                  state_in = ST_O_RD;
               end else begin
                  heap_phase_in = 1'b1;
                  k_in          = len_in >> 1;
                  state_in      = ST_H_RD;
               end
            end
         end
         ST_H_RD: begin
            ra_addr  = km1[AW-1:0];
            state_in = ST_H_LD;
         end
         ST_H_LD: begin
            cur_in   = ra_data;
            pos_in   = km1[AW-1:0];
            len_in_r = n_ff;
            state_in = ST_S_RD;
         end
         ST_S_RD: begin
            ra_addr  = lc_ok ? lc[AW-1:0] : '0;
            rb_addr  = rc_ok ? rc[AW-1:0] : '0;
            state_in = ST_S_CMP;
         end
         ST_S_CMP: begin
            // move the hole down, or drop the held value into it
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = move ? child_val : cur_ff;
            if (move) begin
               pos_in   = child_idx;
               state_in = ST_S_RD;
            end else if (heap_phase_ff) begin
               if (k_ff == CW'(1)) begin
                  heap_phase_in = 1'b0;
                  k_in          = n_ff - CW'(1);
                  state_in      = ST_X_RD;
               end else begin
                  k_in     = km1;
                  state_in = ST_H_RD;
               end
            end else begin
               if (k_ff == CW'(1)) begin
                  k_in     = '0;
                  state_in = ST_O_RD;
               end else begin
                  k_in     = km1;
                  state_in = ST_X_RD;
               end
            end
         end
         ST_X_RD: begin
            ra_addr  = '0;
            rb_addr  = k_ff[AW-1:0];
            state_in = ST_X_WR;
         end
         ST_X_WR: begin
            // old root goes to the tail, tail value sifts from the root
            mem_we    = 1'b1;
            mem_waddr = k_ff[AW-1:0];
            mem_wdata = ra_data;
            cur_in    = rb_data;
            pos_in    = '0;
            len_in_r  = k_ff;
            state_in  = ST_S_RD;
         end
         ST_O_RD: begin
            ra_addr  = k_ff[AW-1:0];
            state_in = ST_O_LD;
         end
         ST_O_LD: begin
            ra_addr = k_ff[AW-1:0];
            if (out_room) begin
               status.emit = 1'b1;
               status.last = (k_ff == n_ff - CW'(1));
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = ST_O_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         heap_phase_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         heap_phase_ff <= heap_phase_in;
      end
      n_ff   <= n_in;
      len_ff <= len_in_r;
      k_ff   <= k_in;
      pos_ff <= pos_in;
      cur_ff <= cur_in;
   end

endmodule : hsb_engine
`default_nettype wire

### sv/heap_sort_batch.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heap_sort_batch: batch sorter, ascending, heapsort in a single memory
// Loads signed values into a store and emits each batch in sorted order.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one value per item, batch_end high on the last one. While
//    loading, an item is taken every cycle. Items past DEPTH are dropped
//    and the whole batch is then reported with clipped set.
//  - After the batch_end item, req_stall rises and the store is sorted in
//    place: a max-heap build, then n-1 root extractions. Each sift starts with
//    its setup states (ST_H_RD, ST_H_LD in the build; ST_X_RD, ST_X_WR per
//    extraction), then per level one two-port read of both children and one
//    compare-and-write step; the sort time is bounded by the single store
//    and its registered read.
//  - rsp channel: n items, ascending, final_flag on the last. The first
//    result comes out once the sort of the batch is done.
//  - A result waits in the output register while rsp_stall is high; the
//    sequencer holds until the register frees. Once the last result sits in
//    that register, req_stall drops and the next batch can load.
//  - Reset clears the load count, the overflow flag and the sequencer; the
//    store content is not cleared and is only ever used after it is written.
// ----------------------------------------------------------------------------
module heap_sort_batch #(
   parameter int DEPTH = hsb_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire hsb_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output hsb_pkg::rsp_type      rsp_data
);
   import hsb_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   eng_status_type    eng_status;
   logic [DATA_W-1:0] eng_value;
   logic              eng_we;
   logic [AW-1:0]     eng_waddr;
   logic [DATA_W-1:0] eng_wdata;
   logic [AW-1:0]     ra_addr, rb_addr;
   logic [DATA_W-1:0] ra_data, rb_data;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [DATA_W-1:0] mem_wdata;

   logic [CW-1:0]     count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic              clip_ff, clip_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept, full, start, out_room;
   logic [CW-1:0]     batch_len;

   // Load side: idle sequencer takes one item per cycle
   assign req_stall = eng_status.busy;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(DEPTH));
   assign start     = accept && req_data.batch_end;
   assign batch_len = full ? count_ff : count_ff + CW'(1);

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      clip_in     = clip_ff;
      if (accept) begin
         if (req_data.batch_end) begin
            // latch the batch clip status, restart the load count
            clip_in     = overflow_ff || full;
            count_in    = '0;
            overflow_in = 1'b0;
         end else if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   // Store write port: the loader and the sequencer never overlap
   always_comb begin
      if (eng_status.busy) begin
         mem_we    = eng_we;
         mem_waddr = eng_waddr;
         mem_wdata = eng_wdata;
      end else begin
         mem_we    = accept && !full;
         mem_waddr = count_ff[AW-1:0];
         mem_wdata = req_data.value;
      end
   end

   // Output register parts the sequencer from the receiver
   assign out_room = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_status.emit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.sorted_value = eng_value;
         rsp_data_in.final_flag   = eng_status.last;
         rsp_data_in.clipped      = clip_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      clip_ff     <= clip_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   hsb_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .ra_addr (ra_addr),
      .rb_addr (rb_addr),
      .ra_data (ra_data),
      .rb_data (rb_data)
   );

   hsb_engine #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .len_in    (batch_len),
      .out_room  (out_room),
      .status    (eng_status),
      .out_value (eng_value),
      .mem_we    (eng_we),
      .mem_waddr (eng_waddr),
      .mem_wdata (eng_wdata),
      .ra_addr   (ra_addr),
      .rb_addr   (rb_addr),
      .ra_data   (ra_data),
      .rb_data   (rb_data)
   );

endmodule : heap_sort_batch
`default_nettype wire

### verif/heap_sort_batch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sort_batch_checker: result predictor and scoreboard for the sorter
// Mirrors the batch store, sorts each finished batch and compares results.
// ----------------------------------------------------------------------------
module heap_sort_batch_checker #(
   parameter int DEPTH = hsb_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire hsb_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire hsb_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending_results,
   output int                    batches_sorted,
   output int                    clipped_batches,
   output int                    results_checked
);
   import hsb_pkg::*;

   logic signed [DATA_W-1:0] held_values [DEPTH];
   int                       held_count;
   bit                       dropped_any;
   rsp_type                  sorted_due [$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
      batches_sorted  = 0;
      clipped_batches = 0;
      results_checked = 0;
      held_count      = 0;
      dropped_any     = 1'b0;
   end

   // push the entry at pos down until both children are no larger
   function automatic void sift_down(int heap_len, int pos);
      int                       guard;
      int                       top_idx;
      int                       left_idx;
      int                       right_idx;
      bit                       settled;
      logic signed [DATA_W-1:0] tmp;
      settled = 1'b0;
      for (guard = 0; guard < DEPTH && !settled; guard++) begin
         top_idx   = pos;
         left_idx  = 2 * pos + 1;
         right_idx = 2 * pos + 2;
         if (left_idx < heap_len && held_values[left_idx] > held_values[top_idx])
            top_idx = left_idx;
         if (right_idx < heap_len && held_values[right_idx] > held_values[top_idx])
            top_idx = right_idx;
         if (top_idx == pos) begin
            settled = 1'b1;
         end else begin
            tmp                  = held_values[top_idx];
            held_values[top_idx] = held_values[pos];
            held_values[pos]     = tmp;
            pos                  = top_idx;
         end
      end
   endfunction

   function automatic void heapsort_held(int len);
      int                       k;
      logic signed [DATA_W-1:0] tmp;
      if (len >= 2) begin
         for (k = len / 2; k > 0; k--)
            sift_down(len, k - 1);
         for (k = len - 1; k > 0; k--) begin
            tmp            = held_values[0];
            held_values[0] = held_values[k];
            held_values[k] = tmp;
            sift_down(k, 0);
         end
      end
   endfunction

   // store one value; on batch end sort and queue one result per stored value
   function automatic void take_value(req_type next_item);
      int      k;
      rsp_type due;
      if (held_count < DEPTH) begin
         held_values[held_count] = next_item.value;
         held_count++;
      end else begin
         dropped_any = 1'b1;
      end
      if (next_item.batch_end) begin
         heapsort_held(held_count);
         for (k = 0; k < held_count; k++) begin
            due.sorted_value = held_values[k];
            due.final_flag   = (k == held_count - 1);
            due.clipped      = dropped_any;
            sorted_due.push_back(due);
         end
         batches_sorted++;
         if (dropped_any)
            clipped_batches++;
         held_count  = 0;
         dropped_any = 1'b0;
      end
   endfunction

   function automatic void check_result(rsp_type got);
      rsp_type due;
      if (sorted_due.size() == 0) begin
         $error("unexpected result: sorted_value %0d final_flag %0b clipped %0b",
                got.sorted_value, got.final_flag, got.clipped);
         fail_count++;
      end else begin
         due = sorted_due.pop_front();
         results_checked++;
         if (got.sorted_value !== due.sorted_value) begin
            $error("sorted_value: expected %0d, actual %0d",
                   due.sorted_value, got.sorted_value);
            fail_count++;
         end
         if (got.final_flag !== due.final_flag) begin
            $error("final_flag: expected %0b, actual %0b", due.final_flag, got.final_flag);
            fail_count++;
         end
         if (got.clipped !== due.clipped) begin
            $error("clipped: expected %0b, actual %0b", due.clipped, got.clipped);
            fail_count++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held_count  = 0;
         dropped_any = 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            check_result(rsp_data);
         if (req_valid && !req_stall)
            take_value(req_data);
      end
      pending_results = sorted_due.size();
   end

endmodule : heap_sort_batch_checker

### verif/tb_heap_sort_batch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heap_sort_batch: stimulus and verdict for the batch heap sorter
// Sends directed and random batches with random gaps and result back-pressure;
// a checker beside the block predicts every sorted result and compares it.
// ----------------------------------------------------------------------------
module tb_heap_sort_batch;
   import hsb_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 450;
   localparam int SETTLE_TICKS = 20;

   // value mixes for a random batch
   localparam int STYLE_WIDE   = 0;
   localparam int STYLE_NARROW = 1;
   localparam int STYLE_EDGES  = 2;

   localparam logic signed [DATA_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] MIN_VALUE = 32'sh8000_0000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int fail_count;
   int pending_results;
   int batches_sorted;
   int clipped_batches;
   int results_checked;
   int items_sent;

   // values of the batch about to be sent, batch end goes on the last one
   logic signed [DATA_W-1:0] batch_values [$];

   heap_sort_batch #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   heap_sort_batch_checker #(.DEPTH(DEPTH)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .batches_sorted  (batches_sorted),
      .clipped_batches (clipped_batches),
      .results_checked (results_checked)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(15, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value(int style);
      logic signed [DATA_W-1:0] v;
      v = $urandom();
      if (style == STYLE_NARROW) begin
         // tiny range: plenty of equal values and sign changes
         v = $urandom_range(0, 6);
         v = v - 3;
      end else if (style == STYLE_EDGES) begin
         case ($urandom_range(0, 5))
            0: v = MAX_VALUE;
            1: v = MIN_VALUE;
            2: v = '0;
            3: v = -1;
            default: ;
         endcase
      end
      return v;
   endfunction

   // Send batch_values as one batch. Drive at the falling edge, look for
   // acceptance at the rising edge, and keep valid high across items when
   // no gap is wanted so that it is assigned only once per step.
   task automatic send_batch(input bit steady);
      int      gap;
      int      k;
      req_type next_item;
      for (k = 0; k < batch_values.size(); k++) begin
         gap = steady ? 0 : pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         next_item.value     = batch_values[k];
         next_item.batch_end = (k == batch_values.size() - 1);
         req_valid <= 1'b1;
         req_data  <= next_item;
         do @(posedge clock); while (req_stall);
         @(negedge clock);
         items_sent++;
      end
      batch_values.delete();
   endtask

   // Result back-pressure: alternate free runs and stall runs. Free runs are
   // sometimes long so that stretches with no stall at all occur too.
   initial begin
      int run;
      forever begin
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (run) @(negedge clock);
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 4);
         rsp_stall <= 1'b1;
         repeat (run) @(negedge clock);
      end
   end

   initial begin
      int k;
      int len;
      int style;
      int batch_index;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      items_sent = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: single-value batches at both extremes.
      batch_values.push_back(MAX_VALUE);
      send_batch(1'b0);
      batch_values.push_back(MIN_VALUE);
      send_batch(1'b0);
      // Two values, reversed: extremes must swap.
      batch_values.push_back(MAX_VALUE);
      batch_values.push_back(MIN_VALUE);
      send_batch(1'b1);
      // Small values around zero.
      batch_values.push_back(0);
      batch_values.push_back(-1);
      batch_values.push_back(1);
      send_batch(1'b0);
      // Repeated equal values.
      for (k = 0; k < 5; k++)
         batch_values.push_back((k % 2) ? -5 : 5);
      send_batch(1'b0);
      // Strictly descending input.
      for (k = 6; k > 0; k--)
         batch_values.push_back(k);
      send_batch(1'b1);
      // Already ascending input spanning the full range.
      batch_values.push_back(MIN_VALUE);
      batch_values.push_back(-1);
      batch_values.push_back(0);
      batch_values.push_back(MAX_VALUE);
      send_batch(1'b0);

      // Random batches. Open with an exactly full store and with an overrun
      // whose batch end falls on a dropped value; after that mostly short
      // batches and now and then one near or past the store depth.
      batch_index = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (batch_index == 0)
            len = DEPTH;
         else if (batch_index == 1)
            len = DEPTH + 2;
         else if ($urandom_range(0, 11) == 0)
            len = $urandom_range(DEPTH - 2, DEPTH + 4);
         else
            len = $urandom_range(1, 12);
         style = $urandom_range(STYLE_WIDE, STYLE_EDGES);
         for (k = 0; k < len; k++)
            batch_values.push_back(pick_value(style));
         send_batch($urandom_range(0, 3) == 0);
         batch_index++;
      end
      req_valid <= 1'b0;

      // Drain: wait for every predicted result, then watch for strays.
      wait (pending_results == 0);
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("Sent %0d items in %0d batches, %0d of them clipped past the store depth.",
               items_sent, batches_sorted, clipped_batches);
      $display("Checked %0d sorted results with %0d mismatches.",
               results_checked, fail_count);
      if (fail_count == 0) begin
         $display("PASS heap_sort_batch");
      end else begin
         $display("FAIL heap_sort_batch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #1_000_000;
      $display("Timeout with %0d results still outstanding.", pending_results);
      $display("FAIL heap_sort_batch");
      $finish;
   end

endmodule : tb_heap_sort_batch

### files.f
sv/hsb_pkg.sv
sv/hsb_store.sv
sv/hsb_engine.sv
sv/heap_sort_batch.sv
verif/heap_sort_batch_checker.sv
verif/tb_heap_sort_batch.sv
